[rtl/core/fnvh_pkg.sv]
// Shared constants, types and the FNV prime multiply for the FNV-1a hash block.
`default_nettype none

package fnvh_pkg;

    localparam int HASH_W   = 64;
    localparam int BUCKET_W = 32;
    localparam int BYTE_W   = 8;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;

    // Two-entry queue between the hashing front and the modulo back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Multiply by the FNV prime 2^40 + 0x1b3 modulo 2^64, as a sum of shifts.
    // The low term 0x1b3 is 256 + 128 + 32 + 16 + 2 + 1.
    function automatic logic [HASH_W-1:0] fnv_mul_prime(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] sum;
        begin
            sum = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
            return sum;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/fnv1a64_hash_bucket.sv]
// Top level of the FNV-1a 64-bit hash with bucket index.
`default_nettype none

// The block hashes a message one byte per beat with 64-bit FNV-1a and, on the
// beat marked last, returns the final hash and the hash modulo num_buckets
// (zero when num_buckets is zero). The front part takes one byte every cycle
// while in_stall is low; a beat with has_byte low and last_byte high closes a
// message without adding a byte. Each finished hash waits in a two-entry queue
// for the back part, whose bit-serial modulo unit loads it, runs 64 divide steps
// and moves the result into the output register, waiting while out_stall holds
// a previous result there. Messages whose bytes last at least one pass of the
// modulo unit stream at one byte per cycle while out_stall is low; a run of
// shorter messages is paced by the modulo unit, and in_stall rises while the
// queue is full. num_buckets is accepted on any cycle and should be changed
// only while no message is in flight.
module fnv1a64_hash_bucket (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fnvh_pkg::BUCKET_W-1:0] cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          has_byte,
    input  wire logic                          last_byte,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [63:0]                        hash_value,
    output logic [31:0]                        bucket_index
);
    import fnvh_pkg::*;

    logic [BUCKET_W-1:0] num_buckets_reg;
    q_status_t           q_status;
    logic                q_push;
    logic                q_pop;
    logic [HASH_W-1:0]   q_wdata;
    logic [HASH_W-1:0]   q_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_buckets_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            num_buckets_reg <= cfg_data;
        end
    end

    fnvh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .last_byte (last_byte),
        .q_status  (q_status),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    fnvh_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    fnvh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_rdata      (q_rdata),
        .q_pop        (q_pop),
        .num_buckets  (num_buckets_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hash_value   (hash_value),
        .bucket_index (bucket_index)
    );

endmodule

`default_nettype wire

[rtl/core/fnvh_front.sv]
// Front part: accepts message bytes and keeps the running FNV-1a hash.
`default_nettype none

module fnvh_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    data_byte,
    input  wire logic                          has_byte,
    input  wire logic                          last_byte,
    input  wire fnvh_pkg::q_status_t           q_status,
    output logic                               q_push,
    output logic [fnvh_pkg::HASH_W-1:0]        q_wdata
);
    import fnvh_pkg::*;

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;
    logic [HASH_W-1:0] mixed;
    logic [HASH_W-1:0] hashed;
    logic              accept;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        mixed  = hash_reg ^ {{(HASH_W-BYTE_W){1'b0}}, data_byte};
        hashed = has_byte ? fnv_mul_prime(mixed) : hash_reg;
        hash_next = hash_reg;
        if (accept)
        begin
            hash_next = last_byte ? FNV_BASIS : hashed;
        end
    end

    // A message end hands the finished hash to the back part.
    assign q_push  = accept && last_byte;
    assign q_wdata = hashed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/fnvh_queue.sv]
// Two-entry queue of finished hashes between the front and back parts.
`default_nettype none

module fnvh_queue (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic [fnvh_pkg::HASH_W-1:0]   wdata,
    input  wire logic                          pop,
    output logic [fnvh_pkg::HASH_W-1:0]        rdata,
    output fnvh_pkg::q_status_t                status
);
    import fnvh_pkg::*;

    logic [HASH_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/fnvh_back.sv]
// Back part: bucket index by bit-serial restoring modulo, and the output register.
`default_nettype none

module fnvh_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fnvh_pkg::q_status_t           q_status,
    input  wire logic [fnvh_pkg::HASH_W-1:0]   q_rdata,
    output logic                               q_pop,
    input  wire logic [fnvh_pkg::BUCKET_W-1:0] num_buckets,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [fnvh_pkg::HASH_W-1:0]        hash_value,
    output logic [fnvh_pkg::BUCKET_W-1:0]      bucket_index
);
    import fnvh_pkg::*;

    localparam int CNT_W = $clog2(HASH_W);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_HOLD = 3'b100
    } back_state_t;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [HASH_W-1:0]   hash_reg;
    logic [HASH_W-1:0]   hash_next;
    logic [HASH_W-1:0]   dvd_reg;
    logic [HASH_W-1:0]   dvd_next;
    logic [BUCKET_W-1:0] rem_reg;
    logic [BUCKET_W-1:0] rem_next;
    logic [BUCKET_W-1:0] div_reg;
    logic [BUCKET_W-1:0] div_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [HASH_W-1:0]   hash_out_reg;
    logic [HASH_W-1:0]   hash_out_next;
    logic [BUCKET_W-1:0] bucket_out_reg;
    logic [BUCKET_W-1:0] bucket_out_next;
    logic [BUCKET_W:0]   partial;
    logic [BUCKET_W+1:0] diff;
    logic                fits;
    logic                out_free;

    assign out_valid    = out_valid_reg;
    assign hash_value   = hash_out_reg;
    assign bucket_index = bucket_out_reg;
    assign out_free     = !out_valid_reg || !out_stall;
    assign q_pop        = (state_reg == S_IDLE) && !q_status.empty;

    // One restoring step: bring down the next dividend bit and try the subtract.
    always_comb
    begin
        partial = {rem_reg, dvd_reg[HASH_W-1]};
        diff    = {1'b0, partial} - {2'b00, div_reg};
        fits    = !diff[BUCKET_W+1];
    end

    always_comb
    begin
        state_next      = state_reg;
        hash_next       = hash_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        hash_out_next   = hash_out_reg;
        bucket_out_next = bucket_out_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    hash_next  = q_rdata;
                    dvd_next   = q_rdata;
                    rem_next   = '0;
                    div_next   = num_buckets;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next = fits ? diff[BUCKET_W-1:0] : partial[BUCKET_W-1:0];
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(HASH_W - 1))
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    hash_out_next   = hash_reg;
                    // A zero bucket count always gives bucket zero.
                    bucket_out_next = (div_reg == '0) ? '0 : rem_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        hash_reg       <= hash_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        hash_out_reg   <= hash_out_next;
        bucket_out_reg <= bucket_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire
